// File: rtl/samp_pkg.sv
// shared types and constants for the stepper angle move pulser
package samp_pkg;

  localparam int ANGLE_W = 24;
  localparam int MAG_W = ANGLE_W + 1;
  localparam int CFG_W = 16;
  localparam int GEAR_W = 2 * CFG_W;
  localparam int PROD_W = MAG_W + GEAR_W;
  localparam int STEP_W = 32;
  localparam int PHASE_W = 16;
  localparam int ANGLE_DIVISOR = 3600000;

  // divide by 3600000 as a shift by 7 and a divide by 28125
  localparam int DIV_SHIFT = 7;
  localparam int DIV_DEN = ANGLE_DIVISOR >> DIV_SHIFT;
  localparam int DEN_W = $clog2(DIV_DEN);
  localparam int SAT_W = PROD_W - STEP_W - DIV_SHIFT;
  localparam int DIGIT_W = 16;
  localparam int DIGIT_X_W = DEN_W + DIGIT_W;
  localparam int RECIP_W = 32;
  localparam int RECIP_SHIFT = DIGIT_X_W + DEN_W;
  localparam logic [RECIP_W-1:0] DEN_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_DEN) - 64'd1) / 64'(DIV_DEN));
  localparam int RECIP_PROD_W = RECIP_SHIFT + DIGIT_W;
  localparam int DIV_DIGITS = STEP_W / DIGIT_W;
  localparam int DIV_CNT_W = $clog2(2 * DIV_DIGITS);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_HUNDREDTHS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd2;

  localparam logic [CFG_W-1:0] STEPS_PER_REV_RST = 16'd3200;
  localparam logic [CFG_W-1:0] GEAR_HUNDREDTHS_RST = 16'd371;
  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd400;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rej;
    logic tick;
    logic start;
    logic mul;
    logic div_init;
    logic div_mul;
    logic div_red;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic moving;
    logic same_angle;
  } dp_sts_t;

endpackage

// File: rtl/samp_ctrl.sv
// controller: sequences ticks, commands and the step count division
module samp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  samp_pkg::dp_sts_t  sts,
  output samp_pkg::dp_cmd_t  cmd
);

  samp_pkg::state_t state_r, state_nxt;
  logic [samp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign out_valid = out_valid_r;
  assign in_ready = (state_r == samp_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= samp_pkg::ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      samp_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          if (!in_mode) begin
            cmd.tick = 1'b1;
            out_valid_nxt = 1'b1;
          end else if (sts.moving) begin
            cmd.rej = 1'b1;
            out_valid_nxt = 1'b1;
          end else if (sts.same_angle) begin
            out_valid_nxt = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = samp_pkg::ST_MUL;
          end
        end
      end
      samp_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = samp_pkg::ST_DIV_INIT;
      end
      samp_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = samp_pkg::ST_DIV;
      end
      samp_pkg::ST_DIV: begin
        // even count: reciprocal multiply, odd count: remainder and digit
        cmd.div_mul = !cnt_r[0];
        cmd.div_red = cnt_r[0];
        cnt_nxt = cnt_r + samp_pkg::DIV_CNT_W'(1);
        if (cnt_r == '1) begin
          state_nxt = samp_pkg::ST_COMMIT;
        end
      end
      samp_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = samp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = samp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/samp_datapath.sv
// datapath: config registers, angle and step state, multiply and reciprocal divide
module samp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [samp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [samp_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [samp_pkg::ANGLE_W-1:0] in_target_angle,
  input  samp_pkg::dp_cmd_t                   cmd,
  output samp_pkg::dp_sts_t                   sts,
  output logic                                out_enable,
  output logic                                out_direction,
  output logic                                out_pulse,
  output logic                                out_busy_res,
  output logic                                out_rejected
);

  logic [samp_pkg::CFG_W-1:0] spr_r, gear_r, half_r;

  logic signed [samp_pkg::ANGLE_W-1:0] cur_r, cur_nxt;
  logic [samp_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic [samp_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic pulse_r, pulse_nxt;
  logic dir_r, dir_nxt;
  logic moving_r, moving_nxt;
  logic rej_r;

  logic signed [samp_pkg::ANGLE_W-1:0] tgt_r;
  logic dirp_r;
  logic [samp_pkg::MAG_W-1:0] mag_r;
  logic [samp_pkg::GEAR_W-1:0] gprod_r;
  logic [samp_pkg::PROD_W-1:0] big_r;
  logic sat_r;
  logic [samp_pkg::DEN_W-1:0] rem_r;
  logic [samp_pkg::STEP_W-1:0] quo_r;
  logic [samp_pkg::RECIP_PROD_W-1:0] rprod_r;

  logic signed [samp_pkg::MAG_W-1:0] cur_ext, tgt_ext;
  logic cur_gt;
  logic [samp_pkg::MAG_W-1:0] mag_w;
  logic [samp_pkg::DIGIT_X_W-1:0] x_w, qd_w, r_w;
  logic [samp_pkg::DIGIT_W-1:0] q_w;
  logic [samp_pkg::PHASE_W-1:0] half_eff, phase_inc;
  logic [samp_pkg::STEP_W-1:0] steps_dec, cnt_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r <= samp_pkg::STEPS_PER_REV_RST;
      gear_r <= samp_pkg::GEAR_HUNDREDTHS_RST;
      half_r <= samp_pkg::HALF_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        samp_pkg::CFG_STEPS_PER_REV:   spr_r <= cfg_data;
        samp_pkg::CFG_GEAR_HUNDREDTHS: gear_r <= cfg_data;
        samp_pkg::CFG_HALF_PERIOD:     half_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // move setup
  assign cur_ext = samp_pkg::MAG_W'(cur_r);
  assign tgt_ext = samp_pkg::MAG_W'(in_target_angle);
  assign cur_gt = cur_r > in_target_angle;
  assign mag_w = cur_gt ? samp_pkg::MAG_W'(cur_ext - tgt_ext)
                        : samp_pkg::MAG_W'(tgt_ext - cur_ext);
  assign sts.same_angle = (cur_r == in_target_angle);
  assign sts.moving = moving_r;

  // one 16-bit quotient digit per reciprocal multiply and remainder step
  assign x_w = {rem_r, quo_r[samp_pkg::STEP_W-1 -: samp_pkg::DIGIT_W]};
  assign q_w = rprod_r[samp_pkg::RECIP_SHIFT +: samp_pkg::DIGIT_W];
  assign qd_w = samp_pkg::DIGIT_X_W'(q_w) * samp_pkg::DIGIT_X_W'(samp_pkg::DIV_DEN);
  assign r_w = x_w - qd_w;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tgt_r <= in_target_angle;
      dirp_r <= cur_gt;
      mag_r <= mag_w;
      gprod_r <= samp_pkg::GEAR_W'(spr_r) * samp_pkg::GEAR_W'(gear_r);
    end
    if (cmd.mul) begin
      big_r <= samp_pkg::PROD_W'(mag_r) * samp_pkg::PROD_W'(gprod_r);
    end
    if (cmd.div_init) begin
      sat_r <= big_r[samp_pkg::PROD_W-1 -: samp_pkg::SAT_W] >=
               samp_pkg::SAT_W'(samp_pkg::DIV_DEN);
      rem_r <= big_r[samp_pkg::STEP_W+samp_pkg::DIV_SHIFT +: samp_pkg::DEN_W];
      quo_r <= big_r[samp_pkg::DIV_SHIFT +: samp_pkg::STEP_W];
    end else if (cmd.div_red) begin
      rem_r <= r_w[samp_pkg::DEN_W-1:0];
      quo_r <= {quo_r[samp_pkg::STEP_W-samp_pkg::DIGIT_W-1:0], q_w};
    end
    if (cmd.div_mul) begin
      rprod_r <= samp_pkg::RECIP_PROD_W'(x_w) * samp_pkg::RECIP_PROD_W'(samp_pkg::DEN_RECIP);
    end
  end

  assign half_eff = (half_r == '0) ? samp_pkg::PHASE_W'(1) : half_r;
  assign phase_inc = phase_r + samp_pkg::PHASE_W'(1);
  assign steps_dec = steps_r - samp_pkg::STEP_W'(1);
  assign cnt_w = sat_r ? '1 : quo_r;

  always_comb begin
    cur_nxt = cur_r;
    steps_nxt = steps_r;
    phase_nxt = phase_r;
    pulse_nxt = pulse_r;
    dir_nxt = dir_r;
    moving_nxt = moving_r;
    if (cmd.tick && moving_r) begin
      if (phase_inc < half_eff) begin
        phase_nxt = phase_inc;
      end else begin
        phase_nxt = '0;
        if (pulse_r) begin
          pulse_nxt = 1'b0;
        end else begin
          steps_nxt = steps_dec;
          if (steps_dec == '0) begin
            moving_nxt = 1'b0;
          end else begin
            pulse_nxt = 1'b1;
          end
        end
      end
    end
    if (cmd.commit) begin
      cur_nxt = tgt_r;
      dir_nxt = dirp_r;
      if (cnt_w != '0) begin
        steps_nxt = cnt_w;
        phase_nxt = '0;
        pulse_nxt = 1'b1;
        moving_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      steps_r <= '0;
      phase_r <= '0;
      pulse_r <= 1'b0;
      dir_r <= 1'b0;
      moving_r <= 1'b0;
      rej_r <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      steps_r <= steps_nxt;
      phase_r <= phase_nxt;
      pulse_r <= pulse_nxt;
      dir_r <= dir_nxt;
      moving_r <= moving_nxt;
      if (cmd.accept) begin
        rej_r <= cmd.rej;
      end
    end
  end

  assign out_enable = moving_r;
  assign out_direction = dir_r;
  assign out_pulse = pulse_r;
  assign out_busy_res = moving_r;
  assign out_rejected = rej_r;

endmodule

// File: rtl/stepper_angle_move_pulser_top.sv
// top level of the stepper angle move pulser
// Input beats carry in_mode (0 = tick, 1 = move command) and a signed
// in_target_angle in hundredths of a degree. Every input beat yields one
// output beat with enable, direction, pulse, busy and rejected levels.
// A tick, a rejected command or a command to the current angle gives its
// output beat in the cycle after acceptance; ticks can run at one per
// cycle while the receiver does not stall. A move command gives its output
// beat after these steps: the gear product is latched at acceptance, then
// the 25 x 32 bit multiply, a step that checks for saturation and drops the
// factor 128 of 3600000, the divide by 28125 (two 16-bit quotient digits,
// each a reciprocal multiply and a remainder step), a commit step and the
// output register; no input beat is taken meanwhile.
// The cfg channel is always ready; index 0 is steps per rev, 1 the gear
// ratio in hundredths, 2 the half period in ticks. Write it only while idle.
// Synchronous active-low reset loads the default config and clears angle,
// step count and all output levels. While the receiver stalls the output
// beat holds and in_ready stays low.
module stepper_angle_move_pulser_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [samp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [samp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic signed [samp_pkg::ANGLE_W-1:0] in_target_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_enable,
  output logic                                out_direction,
  output logic                                out_pulse,
  output logic                                out_busy_res,
  output logic                                out_rejected
);

  samp_pkg::dp_cmd_t cmd;
  samp_pkg::dp_sts_t sts;

  samp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  samp_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_target_angle (in_target_angle),
    .cmd             (cmd),
    .sts             (sts),
    .out_enable      (out_enable),
    .out_direction   (out_direction),
    .out_pulse       (out_pulse),
    .out_busy_res    (out_busy_res),
    .out_rejected    (out_rejected)
  );

endmodule

// File: tb/pulser_beat_check.sv
// beat checker for the stepper angle move pulser: predicts every output beat and compares
module pulser_beat_check
  import samp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_mode,
  input  logic signed [ANGLE_W-1:0]  in_target_angle,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_enable,
  input  logic                       out_direction,
  input  logic                       out_pulse,
  input  logic                       out_busy_res,
  input  logic                       out_rejected,
  output int                         mismatches,
  output int                         pending
);

  typedef struct packed {
    logic enable;
    logic direction;
    logic pulse;
    logic busy;
    logic rejected;
  } levels_t;

  // indexed by bit position of levels_t
  string field_names [5] = '{"rejected", "busy_res", "pulse", "direction", "enable"};

  logic [CFG_W-1:0]          steps_per_rev;
  logic [CFG_W-1:0]          gear_hundredths;
  logic [CFG_W-1:0]          half_period;
  logic signed [ANGLE_W-1:0] cur_angle;
  logic [STEP_W-1:0]         steps_left;
  logic [PHASE_W-1:0]        phase_cnt;
  logic                      pulse_lvl;
  logic                      dir_lvl;
  logic                      moving;

  levels_t beats_due [$];
  levels_t seen;
  levels_t want;

  function automatic levels_t next_levels(input logic is_move,
                                          input logic signed [ANGLE_W-1:0] target);
    logic                rej;
    logic [PHASE_W-1:0]  half;
    longint unsigned     mag;
    longint unsigned     prod;
    longint unsigned     cnt;
    rej = 1'b0;
    half = (half_period == '0) ? PHASE_W'(1) : half_period;
    if (is_move) begin
      if (moving) begin
        rej = 1'b1;
      end else if (target != cur_angle) begin
        if (cur_angle > target) begin
          dir_lvl = 1'b1;
          mag = longint'(cur_angle) - longint'(target);
        end else begin
          dir_lvl = 1'b0;
          mag = longint'(target) - longint'(cur_angle);
        end
        cur_angle = target;
        prod = mag * (64'(steps_per_rev) * 64'(gear_hundredths));
        cnt = prod / 64'(ANGLE_DIVISOR);
        if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
        if (cnt != 0) begin
          steps_left = cnt[STEP_W-1:0];
          phase_cnt = '0;
          pulse_lvl = 1'b1;
          moving = 1'b1;
        end
      end
    end else if (moving) begin
      phase_cnt = phase_cnt + 1'b1;
      if (phase_cnt >= half) begin
        phase_cnt = '0;
        if (pulse_lvl) begin
          pulse_lvl = 1'b0;
        end else begin
          steps_left = steps_left - 1'b1;
          if (steps_left == '0) moving = 1'b0;
          else pulse_lvl = 1'b1;
        end
      end
    end
    return '{moving, dir_lvl, pulse_lvl, moving, rej};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      steps_per_rev = STEPS_PER_REV_RST;
      gear_hundredths = GEAR_HUNDREDTHS_RST;
      half_period = HALF_PERIOD_RST;
      cur_angle = '0;
      steps_left = '0;
      phase_cnt = '0;
      pulse_lvl = 1'b0;
      dir_lvl = 1'b0;
      moving = 1'b0;
      beats_due.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEPS_PER_REV:   steps_per_rev = cfg_data;
          CFG_GEAR_HUNDREDTHS: gear_hundredths = cfg_data;
          CFG_HALF_PERIOD:     half_period = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) beats_due.push_back(next_levels(in_mode, in_target_angle));
      if (out_valid && out_ready) begin
        seen = {out_enable, out_direction, out_pulse, out_busy_res, out_rejected};
        if (beats_due.size() == 0) begin
          $error("output beat with no prediction pending");
          mismatches++;
        end else begin
          want = beats_due.pop_front();
          for (int i = 4; i >= 0; i--) begin
            if (seen[i] !== want[i]) begin
              $error("out_%s: expected %0d, actual %0d", field_names[i], want[i], seen[i]);
              mismatches++;
            end
          end
        end
      end
      pending = beats_due.size();
    end
  end

endmodule

// File: tb/tb_stepper_angle_move_pulser_top.sv
// testbench top for the stepper angle move pulser: stimulus, idling and verdict
module tb_stepper_angle_move_pulser_top;
  import samp_pkg::*;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_MOVE = 1'b1;
  localparam int ANGLE_MAX = (1 << (ANGLE_W - 1)) - 1;
  localparam int ANGLE_MIN = -(1 << (ANGLE_W - 1));
  localparam int CYCLE_LIMIT = 1000000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_mode;
  logic signed [ANGLE_W-1:0] in_target_angle;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_enable;
  logic                      out_direction;
  logic                      out_pulse;
  logic                      out_busy_res;
  logic                      out_rejected;

  int   mismatches;
  int   pending;
  int   snd_idle;
  int   rcv_stall;
  int   n_sent;
  int   aim_base;
  int   cycles;
  logic busy_seen;

  stepper_angle_move_pulser_top DUT (.*);

  pulser_beat_check u_beat_check (.*);

  always #5 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rcv_stall);

  always @(posedge clk) begin
    if (out_valid && out_ready) busy_seen <= out_busy_res;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(input logic mode, input int angle);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_target_angle <= angle[ANGLE_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // tick until the move in progress has finished
  task automatic settle();
    wait_drained();
    while (busy_seen) send_beat(MODE_TICK, int'($urandom));
  endtask

  task automatic configure(input int spr, input int gear, input int half, input int idling);
    logic [CFG_IDX_W-1:0] idx_list [3];
    int                   val_list [3];
    idx_list = '{CFG_STEPS_PER_REV, CFG_GEAR_HUNDREDTHS, CFG_HALF_PERIOD};
    val_list = '{spr, gear, half};
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= val_list[i][CFG_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    case (idling)
      1:       begin snd_idle = 66; rcv_stall = 0;  end
      2:       begin snd_idle = 0;  rcv_stall = 66; end
      3:       begin snd_idle = 16; rcv_stall = 16; end
      default: begin snd_idle = 0;  rcv_stall = 0;  end
    endcase
  endtask

  function automatic int pick_target(input int center, input int span);
    int t;
    t = center + int'($urandom_range(0, 2 * span)) - span;
    if (t > ANGLE_MAX) t = ANGLE_MAX;
    if (t < ANGLE_MIN) t = ANGLE_MIN;
    return t;
  endfunction

  task automatic run_phase(input int spr, input int gear, input int half,
                           input int n_items, input int idling);
    longint gear_prod;
    int     span;
    int     first;
    int     aim;
    configure(spr, gear, half, idling);
    // span of one move chosen so that a move stays at a handful of steps
    gear_prod = longint'(spr) * gear;
    span = (gear_prod >= 18000000) ? 1 : int'(18000000 / gear_prod);
    if (span > ANGLE_MAX) span = ANGLE_MAX;
    first = n_sent;
    while (n_sent - first < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        aim = ($urandom_range(0, 9) == 0) ? aim_base : pick_target(aim_base, span);
        send_beat(MODE_MOVE, aim);
        aim_base = aim;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(0, 3)) send_beat(MODE_TICK, int'($urandom));
          send_beat(MODE_MOVE, pick_target(aim_base, span));
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1) == 0) send_beat(MODE_TICK, int'($urandom));
          else send_beat(MODE_MOVE, pick_target(aim_base, span));
        end
      end
      settle();
    end
    // back to the reference angle before the gearing changes
    send_beat(MODE_MOVE, aim_base);
    settle();
  endtask

  task automatic random_phase(input int n_items, input int idling);
    int spr;
    int lim;
    spr = $urandom_range(1, 65535);
    lim = 36000000 / spr;
    if (lim > 65535) lim = 65535;
    run_phase(spr, $urandom_range(1, lim), $urandom_range(1, 4), n_items, idling);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STEPS_PER_REV;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = MODE_TICK;
    in_target_angle = '0;
    out_ready = 1'b0;
    snd_idle = 0;
    rcv_stall = 0;
    n_sent = 0;
    cycles = 0;
    busy_seen = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, same angle, zero-step moves both ways, busy reject
    configure(STEPS_PER_REV_RST, GEAR_HUNDREDTHS_RST, 2, 0);
    send_beat(MODE_TICK, 0);
    send_beat(MODE_MOVE, 0);
    send_beat(MODE_MOVE, 1);
    send_beat(MODE_MOVE, -2);
    send_beat(MODE_MOVE, 3);
    send_beat(MODE_MOVE, 100);
    settle();
    send_beat(MODE_TICK, -1);
    // angle extremes with the smallest gearing
    configure(1, 1, 1, 0);
    send_beat(MODE_MOVE, ANGLE_MIN);
    settle();
    send_beat(MODE_MOVE, ANGLE_MAX);
    settle();
    send_beat(MODE_MOVE, ANGLE_MAX);
    aim_base = ANGLE_MAX;

    run_phase(1, 1, 1, 260, 0);
    run_phase(STEPS_PER_REV_RST, GEAR_HUNDREDTHS_RST, 3, 260, 1);
    run_phase(65535, 1, 1, 260, 2);
    // zero half period behaves as one
    run_phase(200, 65535, 0, 260, 3);
    random_phase(260, 0);
    random_phase(260, 1);
    random_phase(260, 3);

    // largest settings: step count saturates and the move never ends
    configure(65535, 65535, 65535, 3);
    send_beat(MODE_MOVE, (aim_base >= 0) ? ANGLE_MIN : ANGLE_MAX);
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_beat(MODE_MOVE, int'($urandom));
      else send_beat(MODE_TICK, int'($urandom));
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/samp_pkg.sv
rtl/samp_ctrl.sv
rtl/samp_datapath.sv
rtl/stepper_angle_move_pulser_top.sv
tb/pulser_beat_check.sv
tb/tb_stepper_angle_move_pulser_top.sv
